// ===== design/tsrb_pkg.sv =====
// Shared types for the timestamped sample ring buffer.
// Operation codes and the walk sequencer state; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsrb_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH     = 2'd0,
        FUNC_SNAPSHOT = 2'd1,
        FUNC_SLICE    = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EVAL = 2'd2,
        ST_FIN  = 2'd3
    } state_t;

endpackage

`default_nettype wire

// ===== design/tsrb_ram.sv =====
// Simple dual-port sample store: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsrb_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 112,
    parameter int ADDR_W = 5
) (
    input  wire logic              clk,
    input  wire logic              wen,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              ren,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/timestamped_sample_ring_buffer_core.sv =====
// Top level of the timestamped sample ring buffer.
// Uses tsrb_pkg (codes, states) and tsrb_ram (sample store).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item: push,
//   snapshot, time slice or clear. Output channel (out_valid/out_ready)
//   returns result items, the final one for each input item flagged by last.
//   Push and clear each give one no_data result the next
//   cycle; pushes are accepted every cycle while results drain.
//   A snapshot or slice walks the stored entries oldest to newest, with a
//   read of the store and then a compare for each entry, then a closing
//   step. One matching entry is held back so the last flag can be placed
//   on the final match.
//   An empty ring, an empty window or an inverted window gives one no_data
//   result. Input is refused while a walk runs.
//   Reset clears the write pointer, the full flag and the output valid flag;
//   the store contents are not cleared and are never read before written.
//   When the receiver stalls, the output register holds its item and the
//   walk pauses on the next match.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_sample_ring_buffer_core
    import tsrb_pkg::*;
#(
    parameter int DEPTH         = 32,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int TIME_WIDTH    = 48
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               func,
    input  wire logic [PAYLOAD_WIDTH-1:0] sample_payload,
    input  wire logic [TIME_WIDTH-1:0]    sample_time,
    input  wire logic [TIME_WIDTH-1:0]    window_start,
    input  wire logic [TIME_WIDTH-1:0]    window_end,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [PAYLOAD_WIDTH-1:0]      out_payload,
    output logic [TIME_WIDTH-1:0]         out_time,
    output logic                          no_data,
    output logic                          last
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = PAYLOAD_WIDTH + TIME_WIDTH;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg;
    logic             full_reg;
    logic [PTR_W-1:0] addr_reg;
    logic [CNT_W-1:0] remain_reg;
    logic             filter_reg;
    logic [TIME_WIDTH-1:0] lo_reg;
    logic [TIME_WIDTH-1:0] hi_reg;

    logic                     held_valid_reg;
    logic [PAYLOAD_WIDTH-1:0] held_payload_reg;
    logic [TIME_WIDTH-1:0]    held_time_reg;

    logic                     out_valid_reg;
    logic [PAYLOAD_WIDTH-1:0] out_payload_reg;
    logic [TIME_WIDTH-1:0]    out_time_reg;
    logic                     no_data_reg;
    logic                     last_reg;

    logic slot_free;
    logic in_fire;
    logic is_query;
    logic is_slice;
    logic ring_empty;
    logic inverted;
    logic start_walk;

    logic [ENTRY_W-1:0]       rdata;
    logic [PAYLOAD_WIDTH-1:0] rd_payload;
    logic [TIME_WIDTH-1:0]    rd_time;
    logic                     match;

    // control from the sequencer
    logic mem_ren;
    logic mem_wen;
    logic step;
    logic held_load;
    logic out_load;
    logic out_nodata;
    logic out_last;
    logic stall;

    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && slot_free;
    assign in_fire    = in_valid && in_ready;
    assign is_slice   = (func_t'(func) == FUNC_SLICE);
    assign is_query   = (func_t'(func) == FUNC_SNAPSHOT) || is_slice;
    assign ring_empty = !full_reg && (wp_reg == '0);
    assign inverted   = is_slice && (window_end < window_start);
    assign start_walk = in_fire && is_query && !ring_empty && !inverted;
    assign mem_wen    = in_fire && (func_t'(func) == FUNC_PUSH);

    assign rd_payload = rdata[ENTRY_W-1:TIME_WIDTH];
    assign rd_time    = rdata[TIME_WIDTH-1:0];
    assign match      = !filter_reg ||
                        ((rd_time != '0) && (rd_time >= lo_reg) && (rd_time <= hi_reg));
    assign stall      = match && held_valid_reg && !slot_free;

    tsrb_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (wp_reg),
        .wdata ({sample_payload, sample_time}),
        .ren   (mem_ren),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!stall)
                begin
                    state_next = (remain_reg == CNT_ONE) ? ST_FIN : ST_READ;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mem_ren    = 1'b0;
        step       = 1'b0;
        held_load  = 1'b0;
        out_load   = 1'b0;
        out_nodata = 1'b1;
        out_last   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                out_load = in_fire && !start_walk;
            end
            ST_READ:
            begin
                mem_ren = 1'b1;
            end
            ST_EVAL:
            begin
                if (!stall)
                begin
                    step       = 1'b1;
                    held_load  = match;
                    out_load   = match && held_valid_reg;
                    out_nodata = 1'b0;
                    out_last   = 1'b0;
                end
            end
            ST_FIN:
            begin
                out_load   = slot_free;
                out_nodata = !held_valid_reg;
            end
            default:
            begin
                mem_ren = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                unique case (func_t'(func))
                    FUNC_PUSH:
                    begin
                        if (wp_reg == PTR_LAST)
                        begin
                            wp_reg   <= '0;
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            wp_reg <= wp_reg + 1'b1;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        wp_reg   <= '0;
                        full_reg <= 1'b0;
                    end
                    default:
                    begin
                        wp_reg <= wp_reg;
                    end
                endcase
            end
            // the held entry stays until the closing item is loaded for output
            if (start_walk || ((state_reg == ST_FIN) && slot_free))
            begin
                held_valid_reg <= 1'b0;
            end
            else if (held_load)
            begin
                held_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // walk and result datapath
    always_ff @(posedge clk)
    begin
        if (start_walk)
        begin
            addr_reg   <= full_reg ? wp_reg : '0;
            remain_reg <= full_reg ? CNT_FULL : CNT_W'(wp_reg);
            filter_reg <= is_slice;
            lo_reg     <= window_start;
            hi_reg     <= window_end;
        end
        else if (step)
        begin
            addr_reg   <= (addr_reg == PTR_LAST) ? '0 : addr_reg + 1'b1;
            remain_reg <= remain_reg - 1'b1;
        end
        if (out_load)
        begin
            out_payload_reg <= out_nodata ? '0 : held_payload_reg;
            out_time_reg    <= out_nodata ? '0 : held_time_reg;
            no_data_reg     <= out_nodata;
            last_reg        <= out_last;
        end
        if (held_load)
        begin
            held_payload_reg <= rd_payload;
            held_time_reg    <= rd_time;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_payload_reg;
    assign out_time    = out_time_reg;
    assign no_data     = no_data_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
